// ----- design/grid_collision_occupancy_map_assert.svh -----
// ----------------------------------------------------------------------------
// Grid occupancy map assertion macros
// Shared property shorthands for the map's checker.
// ----------------------------------------------------------------------------
`ifndef GRID_COLLISION_OCCUPANCY_MAP_ASSERT_SVH
`define GRID_COLLISION_OCCUPANCY_MAP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define GCOM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid map assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GCOM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid map assertion failed");

`endif

// ----- design/gcom_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid occupancy map package
// Request and response types, request codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package gcom_pkg;

    localparam int COORD_W = 16;
    localparam int OBJ_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    // request codes
    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_CANGO = 3'd1;
    localparam logic [2:0] REQ_MOVE  = 3'd2;
    localparam logic [2:0] REQ_LEAVE = 3'd3;
    localparam logic [2:0] REQ_FIND  = 3'd4;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_MIN_X = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MAX_X = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN_Y = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_MAX_Y = 2'd3;

    typedef struct packed {
        logic [2:0]                req_type;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] current_x;
        logic signed [COORD_W-1:0] current_y;
        logic [OBJ_W-1:0]          object_id;
        logic                      through_objects;
        logic                      claim_cells;
        logic                      in_room;
        logic                      wall_bit;
    } req_t;

    typedef struct packed {
        logic             ok;
        logic [OBJ_W-1:0] occupant;
    } rsp_t;

    // one stored map cell
    typedef struct packed {
        logic             wall;
        logic [OBJ_W-1:0] occupant;
    } cell_t;

endpackage

`default_nettype wire

// ----- design/grid_collision_occupancy_map.sv -----
// Each request is accepted in idle and walks locate, two reads and two write
// slots of the single cell memory (one read and one write port); no new request
// is taken until its response is issued, and a stalled response holds the block.
// Reset: bounds return to 0..63 and a clearing pass writes every one of the
// GRID_WIDTH*GRID_HEIGHT cells (4096 by default) to zero; req_stall stays high.
// ----------------------------------------------------------------------------
// Grid occupancy map
// Wall bits and occupant ids over a configurable world window.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_collision_occupancy_map
    import gcom_pkg::*;
#(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wen,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire req_t              req_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output rsp_t                   rsp_data
);

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int ROW_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_LOCATE = 8'b0000_0100,
        ST_RD_TGT = 8'b0000_1000,
        ST_RD_CUR = 8'b0001_0000,
        ST_DECIDE = 8'b0010_0000,
        ST_WR_TGT = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    // control
    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         clr_idx_reg, clr_idx_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic                     wr_tgt_reg, wr_tgt_next;
    logic signed [CFG_W-1:0]  min_x_reg, min_x_next;
    logic signed [CFG_W-1:0]  max_x_reg, max_x_next;
    logic signed [CFG_W-1:0]  min_y_reg, min_y_next;
    logic signed [CFG_W-1:0]  max_y_reg, max_y_next;

    // payload
    req_t                     req_reg;
    logic                     t_in_reg, c_in_reg;
    logic [COL_W-1:0]         t_col_reg, c_col_reg;
    logic [ROW_W-1:0]         t_row_reg, c_row_reg;
    logic [IDX_W-1:0]         t_idx_reg, c_idx_reg;
    cell_t                    tgt_word_reg;
    cell_t                    mem_rdata_reg;
    logic                     ok_reg, ok_next;
    logic [OBJ_W-1:0]         occ_reg, occ_next;
    rsp_t                     rsp_data_reg;

    // memory port
    cell_t                    cell_mem [DEPTH];
    logic                     mem_re;
    logic [IDX_W-1:0]         mem_raddr;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    cell_t                    mem_wdata;

    // locate results
    logic                     t_in, c_in;
    logic [COL_W-1:0]         t_col, c_col;
    logic [ROW_W-1:0]         t_row, c_row;

    // shared index multiplier
    logic                     mul_in;
    logic [ROW_W-1:0]         mul_row;
    logic [COL_W-1:0]         mul_col;
    logic [IDX_W:0]           idx_full;
    logic [IDX_W-1:0]         idx;

    // decision terms
    cell_t                    cur_word;
    logic                     can_go;
    logic                     holds_obj;
    logic                     rsp_free;

    gcom_locate #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_loc_tgt (
        .x      (req_reg.target_x),
        .y      (req_reg.target_y),
        .min_x  (min_x_reg),
        .max_x  (max_x_reg),
        .min_y  (min_y_reg),
        .max_y  (max_y_reg),
        .in_map (t_in),
        .col    (t_col),
        .row    (t_row)
    );

    gcom_locate #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_loc_cur (
        .x      (req_reg.current_x),
        .y      (req_reg.current_y),
        .min_x  (min_x_reg),
        .max_x  (max_x_reg),
        .min_y  (min_y_reg),
        .max_y  (max_y_reg),
        .in_map (c_in),
        .col    (c_col),
        .row    (c_row)
    );

    // target index in RD_TGT, current index in RD_CUR
    assign mul_in   = (state_reg == ST_RD_TGT) ? t_in_reg : c_in_reg;
    assign mul_row  = (state_reg == ST_RD_TGT) ? t_row_reg : c_row_reg;
    assign mul_col  = (state_reg == ST_RD_TGT) ? t_col_reg : c_col_reg;
    assign idx_full = (IDX_W+1)'(mul_row) * (IDX_W+1)'(GRID_WIDTH) + (IDX_W+1)'(mul_col);
    // an outside cell reads entry 0; its data is never used
    assign idx      = mul_in ? idx_full[IDX_W-1:0] : '0;

    assign cur_word  = mem_rdata_reg;
    assign can_go    = t_in_reg && !tgt_word_reg.wall
                    && (req_reg.through_objects || (tgt_word_reg.occupant == '0));
    assign holds_obj = (cur_word.occupant == req_reg.object_id);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        wr_tgt_next    = wr_tgt_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        ok_next        = ok_reg;
        occ_next       = occ_reg;
        req_stall      = 1'b1;
        mem_re         = 1'b0;
        mem_raddr      = idx;
        mem_we         = 1'b0;
        mem_waddr      = c_idx_reg;
        mem_wdata      = '{wall: cur_word.wall, occupant: '0};

        if (cfg_wen)
        begin
            case (cfg_index)
                CFG_MIN_X: min_x_next = cfg_wdata;
                CFG_MAX_X: max_x_next = cfg_wdata;
                CFG_MIN_Y: min_y_next = cfg_wdata;
                CFG_MAX_Y: max_y_next = cfg_wdata;
                default:   ;
            endcase
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
                if (clr_idx_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    state_next = ST_LOCATE;
                end
            end
            ST_LOCATE:
            begin
                state_next = ST_RD_TGT;
            end
            ST_RD_TGT:
            begin
                mem_re     = 1'b1;
                state_next = ST_RD_CUR;
            end
            ST_RD_CUR:
            begin
                mem_re     = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // reads of this request are done, so writes cannot race them
                ok_next     = 1'b0;
                occ_next    = '0;
                wr_tgt_next = 1'b0;
                case (req_reg.req_type)
                    REQ_LOAD:
                    begin
                        ok_next   = t_in_reg;
                        mem_we    = t_in_reg;
                        mem_waddr = t_idx_reg;
                        mem_wdata = '{wall: req_reg.wall_bit,
                                      occupant: tgt_word_reg.occupant};
                    end
                    REQ_CANGO:
                    begin
                        ok_next = can_go;
                    end
                    REQ_MOVE:
                    begin
                        ok_next     = req_reg.in_room && can_go && c_in_reg;
                        mem_we      = ok_next && req_reg.claim_cells && holds_obj;
                        wr_tgt_next = ok_next && req_reg.claim_cells;
                    end
                    REQ_LEAVE:
                    begin
                        ok_next = req_reg.in_room && c_in_reg;
                        mem_we  = ok_next && holds_obj;
                    end
                    REQ_FIND:
                    begin
                        ok_next  = t_in_reg;
                        occ_next = t_in_reg ? tgt_word_reg.occupant : '0;
                    end
                    default: ;
                endcase
                state_next = ST_WR_TGT;
            end
            ST_WR_TGT:
            begin
                // claim after the clear, so a move onto its own cell keeps the id
                mem_we     = wr_tgt_reg;
                mem_waddr  = t_idx_reg;
                mem_wdata  = '{wall: 1'b0, occupant: req_reg.object_id};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            wr_tgt_reg    <= 1'b0;
            min_x_reg     <= 16'sd0;
            max_x_reg     <= 16'sd63;
            min_y_reg     <= 16'sd0;
            max_y_reg     <= 16'sd63;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            wr_tgt_reg    <= wr_tgt_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg  <= ok_next;
        occ_reg <= occ_next;
        if (state_reg == ST_IDLE && req_valid)
        begin
            req_reg <= req_data;
        end
        if (state_reg == ST_LOCATE)
        begin
            t_in_reg  <= t_in;
            t_col_reg <= t_col;
            t_row_reg <= t_row;
            c_in_reg  <= c_in;
            c_col_reg <= c_col;
            c_row_reg <= c_row;
        end
        if (state_reg == ST_RD_TGT)
        begin
            t_idx_reg <= idx;
        end
        if (state_reg == ST_RD_CUR)
        begin
            c_idx_reg    <= idx;
            tgt_word_reg <= mem_rdata_reg;
        end
        if (state_reg == ST_DONE && rsp_free)
        begin
            rsp_data_reg <= '{ok: ok_reg, occupant: occ_reg};
        end
    end

    // cell memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= cell_mem[mem_raddr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

// ----- design/gcom_locate.sv -----
// ----------------------------------------------------------------------------
// Grid occupancy map cell locator
// Bounds check of a world coordinate and its column and row in the grid.
// ----------------------------------------------------------------------------
`default_nettype none

module gcom_locate
    import gcom_pkg::*;
#(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
)
(
    input  wire logic signed [COORD_W-1:0] x,
    input  wire logic signed [COORD_W-1:0] y,
    input  wire logic signed [CFG_W-1:0]   min_x,
    input  wire logic signed [CFG_W-1:0]   max_x,
    input  wire logic signed [CFG_W-1:0]   min_y,
    input  wire logic signed [CFG_W-1:0]   max_y,
    output logic                           in_map,
    output logic [((GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1)-1:0]   col,
    output logic [((GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1)-1:0] row
);

    localparam int COL_W = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int ROW_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

    logic [COORD_W:0] col_full;
    logic [COORD_W:0] row_full;
    logic             in_window;

    // both differences are non-negative whenever the window test passes
    assign col_full  = {x[COORD_W-1], x} - {min_x[CFG_W-1], min_x};
    assign row_full  = {max_y[CFG_W-1], max_y} - {y[COORD_W-1], y};
    assign in_window = (x >= min_x) && (x <= max_x) && (y >= min_y) && (y <= max_y);

    assign in_map = in_window
                 && (col_full < (COORD_W+1)'(GRID_WIDTH))
                 && (row_full < (COORD_W+1)'(GRID_HEIGHT));
    assign col    = col_full[COL_W-1:0];
    assign row    = row_full[ROW_W-1:0];

endmodule

`default_nettype wire

// ----- design/gcom_checker.sv -----
// ----------------------------------------------------------------------------
// Grid occupancy map checker
// Port-level checks of handshakes and failed responses, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_collision_occupancy_map_assert.svh"

module gcom_checker
    import gcom_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_stall,
    input  wire req_t req_data,
    input  wire logic rsp_valid,
    input  wire logic rsp_stall,
    input  wire rsp_t rsp_data
);

    logic       req_acc;
    logic       rsp_acc;
    logic [1:0] pending_reg, pending_next;

    assign req_acc = req_valid && !req_stall;
    assign rsp_acc = rsp_valid && !rsp_stall;

    // requests taken but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (req_acc && !rsp_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!req_acc && rsp_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `GCOM_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)
    `GCOM_ASSERT_IMPLY(a_rsp_owed, clk, rst_n, rsp_valid, pending_reg != 2'd0)
    `GCOM_ASSERT_NEXT(a_one_request, clk, rst_n, req_acc, req_stall)
    `GCOM_ASSERT_IMPLY(a_fail_empty, clk, rst_n, rsp_valid && !rsp_data.ok, rsp_data.occupant == 16'd0)
    // a stalled request stays offered and unchanged
    `GCOM_ASSERT_NEXT(a_req_hold, clk, rst_n, req_valid && req_stall, req_valid && $stable(req_data))

endmodule

bind grid_collision_occupancy_map gcom_checker u_gcom_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire
